/* rtl/core/rhsa_pkg.sv */
// Shared constants and types for the RGB/HSV saturation adjust block.
// No dependencies; every other file in rtl/core depends on this package.
package rhsa_pkg;

  localparam int CHANNEL_BITS_DEF  = 8;
  localparam int HUE_FRAC_BITS_DEF = 6;

  localparam int SECTOR_DEG = 60;
  localparam int SAT_W      = 13;
  localparam int SAT_FRAC   = 12;
  localparam int SAT_ONE    = 4096;
  localparam int GAIN_W     = 12;
  localparam int GAIN_FRAC  = 8;
  localparam int GAIN_RESET = 256;
  localparam int HUE_OUT_W  = 15;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // quotient bits resolved per divider stage
  localparam int DIV_STEPS = 4;

  typedef enum logic [1:0] {MAX_RED, MAX_GREEN, MAX_BLUE} max_ch_t;

  typedef enum logic [2:0] {
    SEC_RY, SEC_YG, SEC_GC, SEC_CB, SEC_BM, SEC_MR
  } hue_sector_t;

  typedef enum logic [0:0] {REG_SAT_GAIN = 1'b0} reg_idx_t;

endpackage

/* rtl/core/rhsa_if.sv */
// Valid/ready stream interfaces for input pixels and adjusted results.
// Depends on rhsa_pkg for field widths.
interface rhsa_in_if #(parameter int CB = rhsa_pkg::CHANNEL_BITS_DEF);
  logic          valid;
  logic          ready;
  logic [CB-1:0] red_in;
  logic [CB-1:0] green_in;
  logic [CB-1:0] blue_in;
  modport source(output valid, red_in, green_in, blue_in, input ready);
  modport sink(input valid, red_in, green_in, blue_in, output ready);
endinterface

interface rhsa_out_if #(parameter int CB = rhsa_pkg::CHANNEL_BITS_DEF);
  logic                           valid;
  logic                           ready;
  logic [rhsa_pkg::HUE_OUT_W-1:0] hue_out;
  logic [rhsa_pkg::SAT_W-1:0]     sat_out;
  logic [CB-1:0]                  value_out;
  logic [CB-1:0]                  red_out;
  logic [CB-1:0]                  green_out;
  logic [CB-1:0]                  blue_out;
  modport source(output valid, hue_out, sat_out, value_out, red_out, green_out, blue_out,
                 input ready);
  modport sink(input valid, hue_out, sat_out, value_out, red_out, green_out, blue_out,
               output ready);
endinterface

/* rtl/core/rhsa_div.sv */
// Pipelined restoring divider, DIV_STEPS quotient bits per stage.
// Depends on rhsa_pkg; caller guarantees the quotient fits in QP bits.
module rhsa_div #(
  parameter int DW = 8,
  parameter int QP = 16
) (
  input  logic                            clk,
  input  logic [QP/rhsa_pkg::DIV_STEPS-1:0] en,
  input  logic [DW+QP-1:0]                num,
  input  logic [DW-1:0]                   den,
  output logic [QP-1:0]                   quot
);
  import rhsa_pkg::*;

  localparam int ST = QP / DIV_STEPS;

  logic [DW-1:0] a_r [ST];
  logic [QP-1:0] q_r [ST];
  logic [DW-1:0] d_r [ST];

  for (genvar s = 0; s < ST; s++) begin : g_stage
    logic [DW-1:0] a_in;
    logic [QP-1:0] q_in;
    logic [DW-1:0] a_nx;
    logic [QP-1:0] q_nx;
    logic [DW-1:0] d_in;

    if (s == 0) begin : g_first
      assign a_in = num[DW+QP-1:QP];
      assign q_in = num[QP-1:0];
      assign d_in = den;
    end else begin : g_next
      assign a_in = a_r[s-1];
      assign q_in = q_r[s-1];
      assign d_in = d_r[s-1];
    end

    always_comb begin
      logic [DW:0]   a;
      logic [QP-1:0] q;
      a = {1'b0, a_in};
      q = q_in;
      for (int i = 0; i < DIV_STEPS; i++) begin
        // shift one numerator bit into the partial remainder
        a = {a[DW-1:0], q[QP-1]};
        q = {q[QP-2:0], 1'b0};
        if (a >= {1'b0, d_in}) begin
          a    = a - {1'b0, d_in};
          q[0] = 1'b1;
        end
      end
      a_nx = a[DW-1:0];
      q_nx = q;
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        a_r[s] <= a_nx;
        q_r[s] <= q_nx;
        d_r[s] <= d_in;
      end
    end
  end

  assign quot = q_r[ST-1];

endmodule

/* rtl/core/rgb_hsv_saturation_adjust.sv */
// RGB to HSV conversion with saturation gain and conversion back to RGB.
// Throughput one pixel per cycle while the output is not stalled, set by the
// pipelined divider that resolves four quotient bits per stage.
// Synchronous active-high rst clears all valid bits and loads sat_gain = 1.0.
// Depends on rhsa_pkg, rhsa_if (rhsa_in_if, rhsa_out_if) and rhsa_div.
module rgb_hsv_saturation_adjust #(
  parameter int CHANNEL_BITS  = rhsa_pkg::CHANNEL_BITS_DEF,
  parameter int HUE_FRAC_BITS = rhsa_pkg::HUE_FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  rhsa_in_if.sink                     pix_in,
  rhsa_out_if.source                  pix_out,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rhsa_pkg::APB_AW-1:0] paddr,
  input  logic [rhsa_pkg::APB_DW-1:0] pwdata,
  output logic [rhsa_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);
  import rhsa_pkg::*;

  localparam int CB  = CHANNEL_BITS;
  localparam int U   = SECTOR_DEG << HUE_FRAC_BITS;   // hue units per sector
  localparam int UW  = $clog2(U + 1);
  localparam int HW  = $clog2(6 * U);
  localparam int HXW = $clog2(7 * U + 1);
  localparam int HQW = $clog2(2 * U + 1);
  localparam int QW  = (HQW > SAT_W) ? HQW : SAT_W;
  localparam int ST  = (QW + DIV_STEPS - 1) / DIV_STEPS;
  localparam int QP  = ST * DIV_STEPS;
  localparam int DNW = CB + QP;
  localparam int PPW = CB + SAT_W;
  localparam int PW  = PPW + UW;
  localparam int K   = SAT_FRAC + HUE_FRAC_BITS;       // den = 60 * 2^K
  localparam int WW  = CB + 6;
  localparam int SH  = CB + 12;
  localparam int RW  = CB + 7;
  localparam longint RECIP = ((longint'(1) << SH) + SECTOR_DEG - 1) / SECTOR_DEG;
  localparam int NS  = ST + 7;

  // stage positions
  localparam int S_HUE = ST + 1;
  localparam int S_SAT = ST + 2;
  localparam int S_MUL = ST + 3;
  localparam int S_SCL = ST + 4;
  localparam int S_SUM = ST + 5;
  localparam int S_OUT = ST + 6;

  localparam logic [CB-1:0]  MAXC  = '1;
  localparam logic [HXW-1:0] U1_X  = HXW'(U);
  localparam logic [HXW-1:0] U2_X  = HXW'(2 * U);
  localparam logic [HXW-1:0] U4_X  = HXW'(4 * U);
  localparam logic [HXW-1:0] U5_X  = HXW'(5 * U);
  localparam logic [HXW-1:0] U6_X  = HXW'(6 * U);
  localparam logic [HW-1:0]  H1    = HW'(U);
  localparam logic [HW-1:0]  H2    = HW'(2 * U);
  localparam logic [HW-1:0]  H3    = HW'(3 * U);
  localparam logic [HW-1:0]  H4    = HW'(4 * U);
  localparam logic [HW-1:0]  H5    = HW'(5 * U);
  localparam logic [HW-1:0]  H6    = HW'(6 * U);
  localparam logic [SAT_W-1:0] SAT_ONE_V = SAT_W'(SAT_ONE);
  localparam logic [PW:0]    HALF  = (PW + 1)'(longint'(U) << (SAT_FRAC - 1));
  localparam logic [RW-1:0]  RECIP_V = RW'(RECIP);

  // ---------------------------------------------------------------------------
  // Configuration: single gain register, writes land on the access cycle.
  // ---------------------------------------------------------------------------
  logic [GAIN_W-1:0] sat_gain;
  logic              reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (reg_idx_t'(paddr[APB_AW-1]) == REG_SAT_GAIN);
  assign prdata  = reg_hit ? APB_DW'(sat_gain) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      sat_gain <= GAIN_W'(GAIN_RESET);
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      sat_gain <= pwdata[GAIN_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: each stage advances when empty or when the stage after
  // it advances, so bubbles collapse and a stalled output does not block
  // accepting new pixels until the whole pipe is full.
  // ---------------------------------------------------------------------------
  logic [NS-1:0] v;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !v[NS-1] || pix_out.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= pix_in.valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  assign pix_in.ready  = en[0];
  assign pix_out.valid = v[NS-1];

  // ---------------------------------------------------------------------------
  // Stage 0: max/min, delta, sector numerator, divider operands.
  // ---------------------------------------------------------------------------
  logic [CB-1:0]  c_r, c_g, c_b, c_mx, c_mn, c_dl;
  logic [CB:0]    c_t;
  max_ch_t        c_mch;
  logic [DNW-1:0] c_snum, c_hnum;

  always_comb begin
    c_r = pix_in.red_in;
    c_g = pix_in.green_in;
    c_b = pix_in.blue_in;
    c_mx = c_r;
    c_mn = c_r;
    if (c_g > c_mx) c_mx = c_g;
    if (c_b > c_mx) c_mx = c_b;
    if (c_g < c_mn) c_mn = c_g;
    if (c_b < c_mn) c_mn = c_b;
    c_dl = c_mx - c_mn;
    // red wins ties, then green
    if (c_mx == c_r) begin
      c_mch = MAX_RED;
      c_t   = {1'b0, c_g} + {1'b0, c_dl} - {1'b0, c_b};
    end else if (c_mx == c_g) begin
      c_mch = MAX_GREEN;
      c_t   = {1'b0, c_b} + {1'b0, c_dl} - {1'b0, c_r};
    end else begin
      c_mch = MAX_BLUE;
      c_t   = {1'b0, c_r} + {1'b0, c_dl} - {1'b0, c_g};
    end
    c_snum = (DNW'(c_dl) << SAT_FRAC) + DNW'(c_mx >> 1);
    c_hnum = DNW'(c_t) * DNW'(U) + DNW'(c_dl >> 1);
  end

  logic [CB-1:0]  p0_mx, p0_dl;
  logic [DNW-1:0] p0_snum, p0_hnum;
  max_ch_t        p0_mch;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p0_mx   <= c_mx;
      p0_dl   <= c_dl;
      p0_snum <= c_snum;
      p0_hnum <= c_hnum;
      p0_mch  <= c_mch;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 1..ST: two dividers in lockstep (saturation and sector fraction).
  // ---------------------------------------------------------------------------
  logic [QP-1:0] q_sat, q_hue;

  rhsa_div #(.DW(CB), .QP(QP)) u_div_sat (
    .clk  (clk),
    .en   (en[ST:1]),
    .num  (p0_snum),
    .den  (p0_mx),
    .quot (q_sat)
  );

  rhsa_div #(.DW(CB), .QP(QP)) u_div_hue (
    .clk  (clk),
    .en   (en[ST:1]),
    .num  (p0_hnum),
    .den  (p0_dl),
    .quot (q_hue)
  );

  logic [CB-1:0] sb_mx  [ST+1];
  logic          sb_dnz [ST+1];
  max_ch_t       sb_mch [ST+1];

  assign sb_mx[0]  = p0_mx;
  assign sb_dnz[0] = (p0_dl != '0);
  assign sb_mch[0] = p0_mch;

  for (genvar k = 1; k <= ST; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (en[k]) begin
        sb_mx[k]  <= sb_mx[k-1];
        sb_dnz[k] <= sb_dnz[k-1];
        sb_mch[k] <= sb_mch[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Hue assembly: add sector base, rotate by one sector, wrap into 0..6U-1.
  // Grey pixels force hue and saturation to zero.
  // ---------------------------------------------------------------------------
  logic [HXW-1:0]   hx_sum, hx_hue, hx_base;
  logic [HW-1:0]    h_hue;
  logic [SAT_W-1:0] h_sat;
  logic [CB-1:0]    h_mx;

  always_comb begin
    case (sb_mch[ST])
      MAX_RED:   hx_base = '0;
      MAX_GREEN: hx_base = U2_X;
      MAX_BLUE:  hx_base = U4_X;
      default:   hx_base = '0;
    endcase
    hx_sum = hx_base + HXW'(q_hue);
    if (hx_sum < U1_X) begin
      hx_hue = hx_sum + U5_X;
    end else begin
      hx_hue = hx_sum - U1_X;
    end
    if (hx_hue >= U6_X) begin
      hx_hue = hx_hue - U6_X;
    end
  end

  always_ff @(posedge clk) begin
    if (en[S_HUE]) begin
      h_hue <= sb_dnz[ST] ? HW'(hx_hue) : '0;
      h_sat <= sb_dnz[ST] ? SAT_W'(q_sat) : '0;
      h_mx  <= sb_mx[ST];
    end
  end

  // ---------------------------------------------------------------------------
  // Gain and sector decode: s2 = min(1.0, sat * gain), fraction within sector.
  // ---------------------------------------------------------------------------
  logic [SAT_W+GAIN_W:0]       g_prod;
  logic [SAT_W+GAIN_W-GAIN_FRAC:0] g_s2w;
  logic [SAT_W-1:0]            g_s2;
  hue_sector_t                 g_sec;
  logic [HW-1:0]               g_f;

  always_comb begin
    g_prod = (SAT_W + GAIN_W + 1)'(h_sat) * (SAT_W + GAIN_W + 1)'(sat_gain)
           + (SAT_W + GAIN_W + 1)'(1 << (GAIN_FRAC - 1));
    g_s2w  = g_prod[SAT_W+GAIN_W:GAIN_FRAC];
    g_s2   = (g_s2w > (SAT_W + GAIN_W - GAIN_FRAC + 1)'(SAT_ONE)) ? SAT_ONE_V
                                                                  : SAT_W'(g_s2w);
    // odd sectors count the fraction down from the sector end
    if (h_hue < H1) begin
      g_sec = SEC_RY;
      g_f   = h_hue;
    end else if (h_hue < H2) begin
      g_sec = SEC_YG;
      g_f   = H2 - h_hue;
    end else if (h_hue < H3) begin
      g_sec = SEC_GC;
      g_f   = h_hue - H2;
    end else if (h_hue < H4) begin
      g_sec = SEC_CB;
      g_f   = H4 - h_hue;
    end else if (h_hue < H5) begin
      g_sec = SEC_BM;
      g_f   = h_hue - H4;
    end else begin
      g_sec = SEC_MR;
      g_f   = H6 - h_hue;
    end
  end

  logic [SAT_W-1:0] s_s2, s_sat;
  logic [HW-1:0]    s_hue;
  logic [UW-1:0]    s_ff;
  hue_sector_t      s_sec;
  logic [CB-1:0]    s_mx;

  always_ff @(posedge clk) begin
    if (en[S_SAT]) begin
      s_s2  <= g_s2;
      s_ff  <= UW'(g_f);
      s_sec <= g_sec;
      s_hue <= h_hue;
      s_sat <= h_sat;
      s_mx  <= h_mx;
    end
  end

  // ---------------------------------------------------------------------------
  // v * s2 and v * (1 - s2).
  // ---------------------------------------------------------------------------
  logic [PPW-1:0]   m_p, m_n;
  logic [UW-1:0]    m_ff;
  hue_sector_t      m_sec;
  logic [HW-1:0]    m_hue;
  logic [SAT_W-1:0] m_sat;
  logic [CB-1:0]    m_mx;

  always_ff @(posedge clk) begin
    if (en[S_MUL]) begin
      m_p   <= PPW'(s_mx) * PPW'(s_s2);
      m_n   <= PPW'(s_mx) * PPW'(SAT_ONE_V - s_s2);
      m_ff  <= s_ff;
      m_sec <= s_sec;
      m_hue <= s_hue;
      m_sat <= s_sat;
      m_mx  <= s_mx;
    end
  end

  // ---------------------------------------------------------------------------
  // Chroma, intermediate and offset in units of 1/(4096*U).
  // ---------------------------------------------------------------------------
  logic [PW-1:0]    k_c, k_x, k_m;
  hue_sector_t      k_sec;
  logic [HW-1:0]    k_hue;
  logic [SAT_W-1:0] k_sat;
  logic [CB-1:0]    k_mx;

  always_ff @(posedge clk) begin
    if (en[S_SCL]) begin
      k_c   <= PW'(m_p) * PW'(U);
      k_x   <= PW'(m_p) * PW'(m_ff);
      k_m   <= PW'(m_n) * PW'(U);
      k_sec <= m_sec;
      k_hue <= m_hue;
      k_sat <= m_sat;
      k_mx  <= m_mx;
    end
  end

  // ---------------------------------------------------------------------------
  // Per-channel sum, add half the denominator, drop the power-of-two part.
  // ---------------------------------------------------------------------------
  logic [PW-1:0] a_r, a_g, a_b;
  logic [PW:0]   t_r, t_g, t_b;

  always_comb begin
    case (k_sec)
      SEC_RY: begin a_r = k_c; a_g = k_x; a_b = '0;  end
      SEC_YG: begin a_r = k_x; a_g = k_c; a_b = '0;  end
      SEC_GC: begin a_r = '0;  a_g = k_c; a_b = k_x; end
      SEC_CB: begin a_r = '0;  a_g = k_x; a_b = k_c; end
      SEC_BM: begin a_r = k_x; a_g = '0;  a_b = k_c; end
      default: begin a_r = k_c; a_g = '0; a_b = k_x; end
    endcase
    t_r = {1'b0, k_m} + {1'b0, a_r} + HALF;
    t_g = {1'b0, k_m} + {1'b0, a_g} + HALF;
    t_b = {1'b0, k_m} + {1'b0, a_b} + HALF;
  end

  logic [WW-1:0]    w_r, w_g, w_b;
  logic [HW-1:0]    w_hue;
  logic [SAT_W-1:0] w_sat;
  logic [CB-1:0]    w_mx;

  always_ff @(posedge clk) begin
    if (en[S_SUM]) begin
      w_r   <= WW'(t_r >> K);
      w_g   <= WW'(t_g >> K);
      w_b   <= WW'(t_b >> K);
      w_hue <= k_hue;
      w_sat <= k_sat;
      w_mx  <= k_mx;
    end
  end

  // ---------------------------------------------------------------------------
  // Divide by 60 through an exact reciprocal, clamp, register outputs.
  // ---------------------------------------------------------------------------
  logic [WW+RW-1:0] d_r, d_g, d_b;
  logic [CB:0]      o_qr, o_qg, o_qb;

  always_comb begin
    d_r  = (WW + RW)'(w_r) * (WW + RW)'(RECIP_V);
    d_g  = (WW + RW)'(w_g) * (WW + RW)'(RECIP_V);
    d_b  = (WW + RW)'(w_b) * (WW + RW)'(RECIP_V);
    o_qr = (CB + 1)'(d_r >> SH);
    o_qg = (CB + 1)'(d_g >> SH);
    o_qb = (CB + 1)'(d_b >> SH);
  end

  logic [HW-1:0]    o_hue;
  logic [SAT_W-1:0] o_sat;
  logic [CB-1:0]    o_mx, o_r, o_g, o_b;

  always_ff @(posedge clk) begin
    if (en[S_OUT]) begin
      o_r   <= (o_qr > {1'b0, MAXC}) ? MAXC : o_qr[CB-1:0];
      o_g   <= (o_qg > {1'b0, MAXC}) ? MAXC : o_qg[CB-1:0];
      o_b   <= (o_qb > {1'b0, MAXC}) ? MAXC : o_qb[CB-1:0];
      o_hue <= w_hue;
      o_sat <= w_sat;
      o_mx  <= w_mx;
    end
  end

  assign pix_out.hue_out   = HUE_OUT_W'(o_hue);
  assign pix_out.sat_out   = o_sat;
  assign pix_out.value_out = o_mx;
  assign pix_out.red_out   = o_r;
  assign pix_out.green_out = o_g;
  assign pix_out.blue_out  = o_b;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // hold a stalled item in every stage
  for (genvar k = 0; k < NS; k++) begin : g_hold_chk
    a_stage_hold: assert property (@(posedge clk) disable iff (rst)
      (v[k] && !en[k]) |=> v[k])
      else $error("pipeline stage dropped a stalled item");
  end

  a_sat_range: assert property (@(posedge clk) disable iff (rst)
    pix_out.valid |-> (o_sat <= SAT_ONE_V))
    else $error("saturation above 1.0");

  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    pix_out.valid |-> (o_hue < H6))
    else $error("hue not wrapped below 360 degrees");

  a_grey: assert property (@(posedge clk) disable iff (rst)
    (pix_out.valid && o_sat == '0) |->
      (o_r == o_mx && o_g == o_mx && o_b == o_mx))
    else $error("grey pixel did not come back grey");

endmodule

/* tb/sv/rhsa_scoreboard.sv */
// Checker for the RGB/HSV saturation adjust block: tracks sat_gain from APB
// writes, predicts each pixel result and compares it. Depends on rhsa_pkg, rhsa_if.
module rhsa_scoreboard (
  input  logic                        clk,
  input  logic                        rst,
  rhsa_in_if                          pix_in,
  rhsa_out_if                         pix_out,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [rhsa_pkg::APB_AW-1:0] paddr,
  input  logic [rhsa_pkg::APB_DW-1:0] pwdata,
  output int                          fail_count,
  output int                          pending,
  output int                          checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import rhsa_pkg::*;

  localparam int unsigned HUE_U = SECTOR_DEG << HUE_FRAC_BITS_DEF;
  localparam int unsigned MAXC  = (1 << CHANNEL_BITS_DEF) - 1;

  typedef struct packed {
    logic [HUE_OUT_W-1:0] hue;
    logic [SAT_W-1:0]     sat;
    logic [7:0]           value;
    logic [7:0]           red;
    logic [7:0]           green;
    logic [7:0]           blue;
  } hsv_px_t;

  logic [GAIN_W-1:0] gain;
  hsv_px_t           expected_px[$];

  function automatic logic [7:0] round_channel(longint unsigned v, longint unsigned den);
    longint unsigned q;
    q = (v + den / 2) / den;
    return (q > MAXC) ? MAXC[7:0] : q[7:0];
  endfunction

  function automatic hsv_px_t adjust_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                           logic [GAIN_W-1:0] gn);
    int unsigned mx, mn, dl, sat, hue, s2, t, base, sector;
    longint unsigned q, den, c, x, m, ff, cr, cg, cb;
    hsv_px_t p;
    mx = r; mn = r; sat = 0; hue = 0;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    dl = mx - mn;
    if (dl > 0) begin
      sat = 32'((longint'(dl) * SAT_ONE + mx / 2) / mx);
      // red wins ties, then green
      if (mx == r) begin
        t = g + dl - b; base = 0;
      end else if (mx == g) begin
        t = b + dl - r; base = 2 * HUE_U;
      end else begin
        t = r + dl - g; base = 4 * HUE_U;
      end
      q = (longint'(t) * HUE_U + dl / 2) / dl;
      if (base + q < HUE_U) hue = 32'(base + q + 5 * HUE_U);
      else hue = 32'(base + q - HUE_U);
      if (hue >= 6 * HUE_U) hue -= 6 * HUE_U;
    end
    s2 = (sat * gn + 128) >> GAIN_FRAC;
    if (s2 > SAT_ONE) s2 = SAT_ONE;
    den = longint'(SAT_ONE) * HUE_U;
    sector = hue / HUE_U;
    ff = hue % HUE_U;
    if (sector[0]) ff = HUE_U - ff;
    c = longint'(mx) * s2 * HUE_U;
    x = longint'(mx) * s2 * ff;
    m = longint'(mx) * den - c;
    case (sector)
      SEC_RY: begin cr = c; cg = x; cb = 0; end
      SEC_YG: begin cr = x; cg = c; cb = 0; end
      SEC_GC: begin cr = 0; cg = c; cb = x; end
      SEC_CB: begin cr = 0; cg = x; cb = c; end
      SEC_BM: begin cr = x; cg = 0; cb = c; end
      default: begin cr = c; cg = 0; cb = x; end
    endcase
    p.hue   = hue[HUE_OUT_W-1:0];
    p.sat   = sat[SAT_W-1:0];
    p.value = mx[7:0];
    p.red   = round_channel(m + cr, den);
    p.green = round_channel(m + cg, den);
    p.blue  = round_channel(m + cb, den);
    return p;
  endfunction

  assign pending = expected_px.size();

  always @(posedge clk) begin
    hsv_px_t got, want;
    if (rst) begin
      gain <= GAIN_W'(GAIN_RESET);
      expected_px.delete();
      fail_count <= 0;
      checked <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == {REG_SAT_GAIN, 2'b00})
        gain <= pwdata[GAIN_W-1:0];
      if (pix_out.valid && pix_out.ready) begin
        got = {pix_out.hue_out, pix_out.sat_out, pix_out.value_out,
               pix_out.red_out, pix_out.green_out, pix_out.blue_out};
        if (expected_px.size() == 0) begin
          $display("%0t: result with nothing expected: hsv %0d/%0d/%0d rgb %0d/%0d/%0d",
                   $time, got.hue, got.sat, got.value, got.red, got.green, got.blue);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_px.pop_front();
          if (got !== want) begin
            $display({"%0t: mismatch expected hsv %0d/%0d/%0d rgb %0d/%0d/%0d,",
                      " got hsv %0d/%0d/%0d rgb %0d/%0d/%0d"},
                     $time, want.hue, want.sat, want.value, want.red, want.green,
                     want.blue, got.hue, got.sat, got.value, got.red, got.green,
                     got.blue);
            fail_count <= fail_count + 1;
          end
          checked <= checked + 1;
        end
      end
      if (pix_in.valid && pix_in.ready)
        expected_px.insert(expected_px.size(),
                           adjust_pixel(pix_in.red_in, pix_in.green_in,
                                        pix_in.blue_in, gain));
    end
  end
endmodule

/* tb/sv/tb.sv */
// Top of the saturation adjust testbench: clock, reset, APB setup, pixel
// stimulus with idling phases. Depends on rhsa_pkg, rhsa_if, rhsa_scoreboard.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rhsa_pkg::*;

  localparam int WATCHDOG   = 5000;
  localparam int LATENCY    = 11;
  localparam int PER_PHASE  = 200;
  localparam int HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;

  rhsa_in_if  pix_in ();
  rhsa_out_if pix_out ();

  int fail_count, pending, checked;
  int send_idle_pct = 0;   // chance per cycle the sender drops valid
  int recv_stall_pct = 0;  // chance per cycle the receiver drops ready
  bit hold_req = 1'b0;     // ask the receiver for one long hold-off
  int hold_left = 0;
  int quiet = 0;

  always #1 clk = ~clk;

  rgb_hsv_saturation_adjust DUT (
    .clk, .rst, .pix_in(pix_in), .pix_out(pix_out),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  rhsa_scoreboard checker_u (
    .clk, .rst, .pix_in(pix_in), .pix_out(pix_out),
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .fail_count, .pending, .checked
  );

  initial begin
    pix_in.valid = 1'b0;
    pix_in.red_in = '0;
    pix_in.green_in = '0;
    pix_in.blue_in = '0;
    pix_out.ready = 1'b0;
  end

  // Receiver: random stalls, plus a long counted hold-off on request so the
  // pipeline fills and backs up into the input.
  always @(negedge clk) begin
    if (hold_req && hold_left == 0) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      pix_out.ready = 1'b0;
    end else begin
      pix_out.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: count cycles with no transfer on either channel.
  always @(posedge clk) begin
    if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time, pending);
      $display("status: fail");
      $finish;
    end
  end

  // APB write: setup, then access; the write lands at the access edge.
  task automatic apb_write(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
    @(negedge clk);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0; paddr = addr; pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  // Drain outstanding results, then let the pipeline empty before a write.
  task automatic wait_idle();
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Offer one pixel; called at a falling edge, returns at a falling edge.
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      pix_in.valid = 1'b0;
      @(negedge clk);
    end
    pix_in.valid = 1'b1;
    pix_in.red_in = r;
    pix_in.green_in = g;
    pix_in.blue_in = b;
    do @(posedge clk); while (!pix_in.ready);
    @(negedge clk);
  endtask

  task automatic send_random();
    logic [7:0] r, g, b;
    int kind;
    kind = int'($urandom_range(9));
    r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
    case (kind)
      0: begin g = r; b = r; end                    // grey
      1: begin r = 8'hFF; b = '0; end               // saturated, one channel pinned
      2: begin g = r + 8'($urandom_range(2)); b = r; end // near grey, tiny delta
      3: begin
        r = 8'($urandom_range(3)); g = 8'($urandom_range(3)); b = 8'($urandom_range(3));
      end
      default: ;
    endcase
    send_pixel(r, g, b);
  endtask

  logic [GAIN_W-1:0] gains[8];
  int idle_send[4] = '{0, 61, 0, 6};
  int idle_recv[4] = '{0, 0, 61, 6};

  initial begin
    gains = '{12'd256, 12'd0, 12'd4095, 12'd128, 12'd384, 12'd1024, 12'd1, 12'd300};
    gains[7] = GAIN_W'($urandom);
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Phase 0 directed: extremes, primaries, secondaries, wrap-around hue,
    // grey and black, at unity gain.
    apb_write({REG_SAT_GAIN, 2'b00}, 32'd256);
    apb_write(3'd4, 32'hFFFF_FFFF);  // unmapped address, must not disturb the gain
    send_pixel(8'd0,   8'd0,   8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd255, 8'd0,   8'd0);
    send_pixel(8'd0,   8'd255, 8'd0);
    send_pixel(8'd0,   8'd0,   8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0,   8'd255, 8'd255);
    send_pixel(8'd255, 8'd0,   8'd255);
    send_pixel(8'd255, 8'd0,   8'd1);
    send_pixel(8'd255, 8'd1,   8'd0);
    send_pixel(8'd1,   8'd0,   8'd0);
    send_pixel(8'd0,   8'd0,   8'd1);
    send_pixel(8'd254, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd254, 8'd254);
    send_pixel(8'd1,   8'd1,   8'd0);
    send_pixel(8'd200, 8'd100, 8'd50);
    send_pixel(8'd10,  8'd250, 8'd130);
    send_pixel(8'd170, 8'd85,  8'd255);

    for (int ph = 0; ph < 8; ph++) begin
      pix_in.valid = 1'b0;
      wait_idle();
      apb_write({REG_SAT_GAIN, 2'b00}, {20'd0, gains[ph]});
      send_idle_pct = idle_send[ph % 4];
      recv_stall_pct = idle_recv[ph % 4];
      if (ph == 2) hold_req = 1'b1;  // receiver blocks while the sender keeps going
      if (ph == 0) begin
        // phase 0 runs all PER_PHASE pixels with neither side idling
        for (int i = 0; i < PER_PHASE; i++) send_random();
      end else begin
        for (int i = 0; i < PER_PHASE; i++) begin
          // stretches with no idling inside every phase
          if (i == PER_PHASE / 2) begin
            send_idle_pct = 0; recv_stall_pct = 0;
          end
          send_random();
        end
      end
    end
    pix_in.valid = 1'b0;
    recv_stall_pct = 0;

    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);

    $display("Covered %0d pixels over 8 gain settings (0, 1, unity, 4095 and others),",
             checked);
    $display("with sender gaps, receiver stalls and one long output hold-off.");
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
